FILE: sv/assert_macros.svh
// Assertion helpers; the using module provides clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define WSG_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define WSG_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/wsg_pkg.sv
`timescale 1ns / 1ps

package wsg_pkg;

	// Datapath sizes
	localparam int PHASE_BITS      = 32;
	localparam int SAMPLE_BITS     = 16;
	localparam int TABLE_ADDR_BITS = 10;
	localparam int COUNT_BITS      = 16;

	localparam int ROM_DEPTH = 1 << TABLE_ADDR_BITS;
	localparam int ROM_WIDTH = SAMPLE_BITS - 1;

	// Stream and register port sizes
	localparam int S_TDATA_BITS   = 8;
	localparam int M_TDATA_BITS   = ((SAMPLE_BITS + COUNT_BITS + 7) / 8) * 8;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 32;
	localparam int WAVE_BITS      = 3;

	// Register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_WAVEFORM     = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP   = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_START_PHASE  = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLE_COUNT = 2'd3;

	// Waveform codes
	localparam logic [WAVE_BITS-1:0] WAVE_SINE     = 3'd0;
	localparam logic [WAVE_BITS-1:0] WAVE_COSINE   = 3'd1;
	localparam logic [WAVE_BITS-1:0] WAVE_SQUARE   = 3'd2;
	localparam logic [WAVE_BITS-1:0] WAVE_SAWTOOTH = 3'd3;

	// Full-scale amplitude and its negation
	localparam logic [SAMPLE_BITS-1:0] AMP     = SAMPLE_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
	localparam logic [SAMPLE_BITS-1:0] AMP_NEG = (~AMP) + SAMPLE_BITS'(1);

	typedef logic [ROM_WIDTH-1:0] rom_word_t;
	typedef rom_word_t rom_image_t [ROM_DEPTH];

	// Item travelling from the phase stage to the output stage
	typedef struct packed {
		logic [SAMPLE_BITS-1:0] direct;
		logic                   use_rom;
		logic                   negate;
		logic [COUNT_BITS-1:0]  index;
		logic                   last;
	} pipe_t;

	// Quarter-wave sine, Q30 Taylor series to the 15th power, rounded to amplitude
	function automatic rom_image_t build_rom();
		rom_image_t img;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [63:0] sum;
		logic signed [63:0] scaled;
		localparam logic [63:0] PI_Q30 = 64'd3373259426;
		localparam logic signed [63:0] ONE_Q30 = 64'sd1 << 30;
		localparam logic signed [63:0] AMP_S = 64'($unsigned(AMP));
		for (int i = 0; i < ROM_DEPTH; i++) begin
			x = (64'(2 * i + 1) * PI_Q30 + (64'd1 << (TABLE_ADDR_BITS + 1)))
				>> (TABLE_ADDR_BITS + 2);
			x2 = (x * x) >> 30;
			term = x;
			sum = $signed(x);
			term = ((term * x2) >> 30) / 64'd6;
			sum = sum - $signed(term);
			term = ((term * x2) >> 30) / 64'd20;
			sum = sum + $signed(term);
			term = ((term * x2) >> 30) / 64'd42;
			sum = sum - $signed(term);
			term = ((term * x2) >> 30) / 64'd72;
			sum = sum + $signed(term);
			term = ((term * x2) >> 30) / 64'd110;
			sum = sum - $signed(term);
			term = ((term * x2) >> 30) / 64'd156;
			sum = sum + $signed(term);
			term = ((term * x2) >> 30) / 64'd210;
			sum = sum - $signed(term);
			if (sum < 0) sum = 0;
			if (sum > ONE_Q30) sum = ONE_Q30;
			scaled = (sum * AMP_S + (ONE_Q30 >>> 1)) >>> 30;
			img[i] = ROM_WIDTH'(scaled);
		end
		return img;
	endfunction

endpackage

FILE: sv/wsg_rom.sv
`timescale 1ns / 1ps

module wsg_rom (
	input  logic                              clk,
	input  logic                              en,
	input  logic [wsg_pkg::TABLE_ADDR_BITS-1:0] addr,
	output wsg_pkg::rom_word_t                data_q
);
	import wsg_pkg::*;

	// Quarter-wave table, fixed at elaboration
	localparam rom_image_t ROM_IMAGE = build_rom();

	// Registered read; data holds while not enabled
	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= ROM_IMAGE[addr];
		end
	end

endmodule

FILE: sv/waveform_sample_generator_core.sv
`timescale 1ns / 1ps
// Phase-accumulator function generator. Each input item is one tick and gives exactly one
// output item: a signed Q1.15 sample (sine, cosine, square or sawtooth by the waveform
// register, zero for other codes), its index within the run, and tlast on the run's final
// sample, after which the run begins again at the start phase. Setting the restart bit of an
// input item starts a fresh run with that tick. One item is taken every clock, except while
// the output stalls with stage 1 full; each result passes through the registered read of the
// 1024-entry quarter-wave sine ROM, followed by the output register. The table is fixed, so no
// initialisation pass is needed after reset. Registers are to be written only while idle.

`include "assert_macros.svh"

module waveform_sample_generator_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// restart (bit 0), zero padding above
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [wsg_pkg::S_TDATA_BITS-1:0]     s_tdata,
	// sample (15:0), sample_index (31:16)
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [wsg_pkg::M_TDATA_BITS-1:0]     m_tdata,
	output logic                                 m_tlast,
	// register write port
	input  logic                                 cfg_we,
	input  logic [wsg_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [wsg_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
	import wsg_pkg::*;

	localparam logic [PHASE_BITS-1:0] QUARTER_TURN = PHASE_BITS'(1) << (PHASE_BITS - 2);
	localparam logic [PHASE_BITS-1:0] HALF_TURN    = PHASE_BITS'(1) << (PHASE_BITS - 1);

	logic [WAVE_BITS-1:0]   wave_q;
	logic [PHASE_BITS-1:0]  step_q;
	logic [PHASE_BITS-1:0]  start_q;
	logic [COUNT_BITS-1:0]  count_q;
	logic [PHASE_BITS-1:0]  acc_q;
	logic [COUNT_BITS-1:0]  pos_q;

	logic                   accept;
	logic                   out_adv;
	logic                   valid_s1;
	pipe_t                  pipe_s0;
	pipe_t                  pipe_s1;
	logic                   restart;
	logic [PHASE_BITS-1:0]  acc_eff;
	logic [COUNT_BITS-1:0]  pos_eff;
	logic [COUNT_BITS:0]    pos_inc;
	logic [PHASE_BITS-1:0]  ph;
	logic [PHASE_BITS-1:0]  tab_ph;
	logic [1:0]             quad;
	logic [TABLE_ADDR_BITS-1:0] raw_addr;
	logic [TABLE_ADDR_BITS-1:0] rom_addr;
	logic [PHASE_BITS+SAMPLE_BITS-1:0] saw_ext;
	logic [SAMPLE_BITS-1:0] saw_top;
	rom_word_t              rom_q;
	logic [SAMPLE_BITS-1:0] rom_ext;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic [COUNT_BITS-1:0]  index_q;
	logic                   last_q;

	// Handshake: stage 1 takes an item when it is empty or when the output register advances
	assign out_adv  = !m_tvalid || m_tready;
	assign s_tready = !valid_s1 || out_adv;
	assign accept   = s_tvalid && s_tready;
	assign restart  = s_tdata[0];

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_q  <= WAVE_SINE;
			step_q  <= '0;
			start_q <= '0;
			count_q <= COUNT_BITS'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WAVEFORM:     wave_q  <= cfg_data[WAVE_BITS-1:0];
				REG_PHASE_STEP:   step_q  <= PHASE_BITS'(cfg_data);
				REG_START_PHASE:  start_q <= PHASE_BITS'(cfg_data);
				REG_SAMPLE_COUNT: count_q <= COUNT_BITS'(cfg_data);
				default: ;
			endcase
		end
	end

	// Phase stage: current phase, run position, end-of-run test
	always_comb begin
		acc_eff  = restart ? '0 : acc_q;
		pos_eff  = restart ? '0 : pos_q;
		ph       = start_q + acc_eff;
		pos_inc  = {1'b0, pos_eff} + (COUNT_BITS+1)'(1);
		tab_ph   = ph + ((wave_q == WAVE_COSINE) ? QUARTER_TURN : '0);
		quad     = tab_ph[PHASE_BITS-1 -: 2];
		raw_addr = tab_ph[PHASE_BITS-3 -: TABLE_ADDR_BITS];
		rom_addr = quad[0] ? ~raw_addr : raw_addr;
		saw_ext  = {ph, SAMPLE_BITS'(0)};
		saw_top  = saw_ext[PHASE_BITS+SAMPLE_BITS-1 -: SAMPLE_BITS];

		pipe_s0.index   = pos_eff;
		pipe_s0.last    = pos_inc >= {1'b0, count_q};
		pipe_s0.negate  = quad[1];
		pipe_s0.use_rom = 1'b0;
		pipe_s0.direct  = '0;
		unique case (wave_q)
			WAVE_SINE, WAVE_COSINE: pipe_s0.use_rom = 1'b1;
			WAVE_SQUARE:   pipe_s0.direct = (ph <= HALF_TURN) ? AMP : AMP_NEG;
			WAVE_SAWTOOTH: pipe_s0.direct = {~saw_top[SAMPLE_BITS-1], saw_top[SAMPLE_BITS-2:0]};
			default: ;
		endcase
	end

	// Accumulator and run position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			pos_q <= '0;
		end else if (accept) begin
			if (pipe_s0.last) begin
				acc_q <= '0;
				pos_q <= '0;
			end else begin
				acc_q <= acc_eff + step_q;
				pos_q <= pos_inc[COUNT_BITS-1:0];
			end
		end
	end

	// Sine table, read issued on acceptance
	wsg_rom u_rom (
		.clk    (clk),
		.en     (accept),
		.addr   (rom_addr),
		.data_q (rom_q)
	);

	// Stage 1 control and payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pipe_s1 <= pipe_s0;
		end
	end

	// Table value with quadrant sign
	always_comb begin
		rom_ext   = {1'b0, rom_q};
		sample_s1 = pipe_s1.direct;
		if (pipe_s1.use_rom) begin
			sample_s1 = pipe_s1.negate ? (~rom_ext + SAMPLE_BITS'(1)) : rom_ext;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_adv) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && valid_s1) begin
			sample_q <= sample_s1;
			index_q  <= pipe_s1.index;
			last_q   <= pipe_s1.last;
		end
	end

	assign m_tdata = M_TDATA_BITS'({index_q, sample_q});
	assign m_tlast = last_q;

	// Checks
	`WSG_ASSERT_NXT(a_restart_index, accept && restart, pipe_s1.index == '0,
		"restart item did not begin at index zero")
	`WSG_ASSERT_NXT(a_last_clears, accept && pipe_s0.last, (pos_q == '0) && (acc_q == '0),
		"run state not cleared after final sample")
	`WSG_ASSERT_NXT(a_s1_hold, valid_s1 && !out_adv, valid_s1 && $stable(pipe_s1),
		"stage 1 item lost while output stalled")
	`WSG_ASSERT_IMP(a_no_accept_stalled, valid_s1 && !out_adv, !s_tready,
		"item accepted into a stalled stage")

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import wsg_pkg::*;

	// Waveform codes outside the four named shapes, all of which give silence
	localparam logic [WAVE_BITS-1:0] WAVE_ZERO     = 3'd4;
	localparam logic [WAVE_BITS-1:0] WAVE_TOP_CODE = 3'd7;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SEG_ITEMS   = 115;

	typedef struct packed {
		logic [WAVE_BITS-1:0]   wave;
		logic [PHASE_BITS-1:0]  step;
		logic [PHASE_BITS-1:0]  start;
		logic [COUNT_BITS-1:0]  count;
	} gen_cfg_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		logic [COUNT_BITS-1:0]  index;
		logic                   last;
	} gen_out_t;

	typedef struct packed {
		logic     pinned;
		gen_out_t want;
	} pin_t;

	typedef struct packed {
		gen_cfg_t cfg;
		logic     restart;
		logic     pinned;
		gen_out_t want;
	} tick_row_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic [S_TDATA_BITS-1:0]   s_tdata = '0;
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [M_TDATA_BITS-1:0]   m_tdata;
	logic                      m_tlast;
	logic                      cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

	// Generator model: registers, accumulator and run position
	logic [WAVE_BITS-1:0]   gen_wave = WAVE_SINE;
	logic [PHASE_BITS-1:0]  gen_step = '0;
	logic [PHASE_BITS-1:0]  gen_start = '0;
	logic [COUNT_BITS-1:0]  gen_count = 16'd1;
	logic [PHASE_BITS-1:0]  gen_acc = '0;
	logic [COUNT_BITS-1:0]  gen_pos = '0;
	logic [ROM_WIDTH-1:0]   qsine [ROM_DEPTH];

	gen_out_t sample_q [$];
	pin_t     pin_q [$];
	int       mismatches = 0;
	int       send_idle_pct = 0;
	int       stall_pct = 0;
	logic     hold_off = 1'b0;
	gen_cfg_t live_cfg;
	logic     have_cfg = 1'b0;

	waveform_sample_generator_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Quarter-wave sine table: Q30 Taylor series, rounded to full scale
	initial begin
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [63:0] acc;
		for (int i = 0; i < ROM_DEPTH; i++) begin
			x = (64'(2 * i + 1) * 64'd3373259426 + (64'd1 << (TABLE_ADDR_BITS + 1)))
				>> (TABLE_ADDR_BITS + 2);
			x2 = (x * x) >> 30;
			term = x;
			acc = $signed(x);
			for (int k = 1; k <= 7; k++) begin
				term = ((term * x2) >> 30) / (64'(2 * k) * 64'(2 * k + 1));
				if (k % 2 == 1) acc = acc - $signed(term);
				else acc = acc + $signed(term);
			end
			if (acc < 0) acc = 0;
			if (acc > (64'sd1 <<< 30)) acc = 64'sd1 <<< 30;
			qsine[i] = ROM_WIDTH'((acc * 64'sd32767 + (64'sd1 <<< 29)) >>> 30);
		end
	end

	function automatic logic [SAMPLE_BITS-1:0] sine_at(input logic [PHASE_BITS-1:0] ph);
		logic [1:0]                 quad;
		logic [TABLE_ADDR_BITS-1:0] addr;
		logic [SAMPLE_BITS-1:0]     mag;
		quad = ph[PHASE_BITS-1 -: 2];
		addr = ph[PHASE_BITS-3 -: TABLE_ADDR_BITS];
		if (quad[0]) addr = ~addr;
		mag = SAMPLE_BITS'(qsine[addr]);
		return quad[1] ? -mag : mag;
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] shape_at(input logic [PHASE_BITS-1:0] ph);
		case (gen_wave)
			WAVE_SINE:     return sine_at(ph);
			WAVE_COSINE:   return sine_at(ph + (PHASE_BITS'(1) << (PHASE_BITS - 2)));
			WAVE_SQUARE:   return (ph <= (PHASE_BITS'(1) << (PHASE_BITS - 1))) ? AMP : AMP_NEG;
			WAVE_SAWTOOTH: return ph[PHASE_BITS-1 -: SAMPLE_BITS] ^ (SAMPLE_BITS'(1) << (SAMPLE_BITS - 1));
			default:       return '0;
		endcase
	endfunction

	// One tick of the generator: emit from the current phase, then advance or wrap the run
	function automatic gen_out_t next_sample(input logic restart);
		gen_out_t o;
		if (restart) begin
			gen_acc = '0;
			gen_pos = '0;
		end
		o.sample = shape_at(gen_start + gen_acc);
		o.index  = gen_pos;
		o.last   = ({1'b0, gen_pos} + 17'd1) >= {1'b0, gen_count};
		if (o.last) begin
			gen_acc = '0;
			gen_pos = '0;
		end else begin
			gen_acc = gen_acc + gen_step;
			gen_pos = gen_pos + 1'b1;
		end
		return o;
	endfunction

	// Register writes, accepted ticks and emitted samples, all seen at the clock edge
	always @(posedge clk) begin
		gen_out_t want;
		gen_out_t got;
		pin_t     pin;
		if (cfg_we) begin
			case (cfg_index)
				REG_WAVEFORM:     gen_wave  = cfg_data[WAVE_BITS-1:0];
				REG_PHASE_STEP:   gen_step  = cfg_data[PHASE_BITS-1:0];
				REG_START_PHASE:  gen_start = cfg_data[PHASE_BITS-1:0];
				REG_SAMPLE_COUNT: gen_count = cfg_data[COUNT_BITS-1:0];
				default: ;
			endcase
		end
		if (s_tvalid && s_tready) begin
			want = next_sample(s_tdata[0]);
			if (pin_q.size() > 0) begin
				pin = pin_q.pop_front();
				if (pin.pinned) want = pin.want;
			end
			sample_q.insert(sample_q.size(), want);
		end
		if (m_tvalid && m_tready) begin
			got.sample = m_tdata[SAMPLE_BITS-1:0];
			got.index  = m_tdata[SAMPLE_BITS +: COUNT_BITS];
			got.last   = m_tlast;
			if (sample_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected sample %h index %0d last %b", got.sample, got.index,
						got.last);
			end else begin
				want = sample_q.pop_front();
				if (got != want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: sample %h/%h index %0d/%0d last %b/%b (exp/act)",
							want.sample, got.sample, want.index, got.index, want.last,
							got.last);
				end
			end
		end
	end

	// Receiver readiness; a hold-off forces back-pressure
	always @(posedge clk) begin
		if (arst_n)
			m_tready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	task automatic send_tick(input logic restart);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= S_TDATA_BITS'(restart);
		do @(posedge clk); while (!s_tready);
	endtask

	// Stop offering, wait until every sample is back and the pipeline is empty;
	// it first waits for a clock edge so the last accepted item is already queued
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sample_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	task automatic apply_cfg(input gen_cfg_t c);
		write_reg(REG_WAVEFORM, CFG_DATA_BITS'(c.wave));
		write_reg(REG_PHASE_STEP, CFG_DATA_BITS'(c.step));
		write_reg(REG_START_PHASE, CFG_DATA_BITS'(c.start));
		write_reg(REG_SAMPLE_COUNT, CFG_DATA_BITS'(c.count));
		cfg_we   <= 1'b0;
		live_cfg = c;
		have_cfg = 1'b1;
	endtask

	function automatic gen_cfg_t pick_cfg();
		gen_cfg_t c;
		c.wave = WAVE_BITS'($urandom_range(0, 7));
		case ($urandom_range(0, 3))
			0: c.step = $urandom;
			1: c.step = $urandom_range(0, 1) ? '1 : '0;
			2: c.step = $urandom_range(1, 1 << 22);
			default: c.step = -PHASE_BITS'($urandom_range(1, 1 << 22));
		endcase
		case ($urandom_range(0, 2))
			0: c.start = $urandom;
			1: c.start = $urandom_range(0, 1) ? '1 : '0;
			default: c.start = PHASE_BITS'($urandom_range(0, 3)) << (PHASE_BITS - 2);
		endcase
		case ($urandom_range(0, 4))
			0: c.count = COUNT_BITS'($urandom_range(0, 1));
			1: c.count = '1;
			2: c.count = COUNT_BITS'($urandom_range(1, 65535));
			default: c.count = COUNT_BITS'($urandom_range(2, 40));
		endcase
		return c;
	endfunction

	task automatic hold_receiver(input int cycles);
		hold_off <= 1'b1;
		repeat (cycles) @(posedge clk);
		hold_off <= 1'b0;
	endtask

	// Directed ticks: settings, restart bit, and a typed sample where it is obvious
	tick_row_t dir_rows [24] = '{
		'{'{WAVE_SINE,     32'h0,        32'h0,        16'd1},     1'b0, 1'b0, '{16'h0000, 16'd0, 1'b0}},
		'{'{WAVE_SQUARE,   32'h0,        32'h0,        16'd1},     1'b1, 1'b1, '{16'h7FFF, 16'd0, 1'b1}},
		'{'{WAVE_SQUARE,   32'h0,        32'h80000000, 16'd1},     1'b0, 1'b1, '{16'h7FFF, 16'd0, 1'b1}},
		'{'{WAVE_SQUARE,   32'h0,        32'h80000001, 16'd1},     1'b0, 1'b1, '{16'h8001, 16'd0, 1'b1}},
		'{'{WAVE_SAWTOOTH, 32'h0,        32'h0,        16'd1},     1'b0, 1'b1, '{16'h8000, 16'd0, 1'b1}},
		'{'{WAVE_SAWTOOTH, 32'h0,        32'hFFFFFFFF, 16'd1},     1'b0, 1'b1, '{16'h7FFF, 16'd0, 1'b1}},
		'{'{WAVE_SINE,     32'h0,        32'h3FFFFFFF, 16'd1},     1'b0, 1'b1, '{16'h7FFF, 16'd0, 1'b1}},
		'{'{WAVE_SINE,     32'h0,        32'hC0000000, 16'd1},     1'b0, 1'b1, '{16'h8001, 16'd0, 1'b1}},
		'{'{WAVE_COSINE,   32'h0,        32'h0,        16'd1},     1'b0, 1'b1, '{16'h7FFF, 16'd0, 1'b1}},
		'{'{WAVE_ZERO,     32'hFFFFFFFF, 32'h12345678, 16'd1},     1'b0, 1'b1, '{16'h0000, 16'd0, 1'b1}},
		'{'{WAVE_COSINE,   32'h0,        32'hC0000000, 16'd1},     1'b0, 1'b0, '{16'h0000, 16'd0, 1'b0}},
		'{'{WAVE_TOP_CODE, 32'h0,        32'hFFFFFFFF, 16'd1},     1'b1, 1'b1, '{16'h0000, 16'd0, 1'b1}},
		'{'{WAVE_SAWTOOTH, 32'h00010000, 32'h0,        16'd0},     1'b0, 1'b1, '{16'h8000, 16'd0, 1'b1}},
		'{'{WAVE_SAWTOOTH, 32'h00010000, 32'h0,        16'd0},     1'b0, 1'b1, '{16'h8000, 16'd0, 1'b1}},
		'{'{WAVE_SAWTOOTH, 32'h40000000, 32'h0,        16'd3},     1'b0, 1'b1, '{16'h8000, 16'd0, 1'b0}},
		'{'{WAVE_SAWTOOTH, 32'h40000000, 32'h0,        16'd3},     1'b0, 1'b1, '{16'hC000, 16'd1, 1'b0}},
		'{'{WAVE_SAWTOOTH, 32'h40000000, 32'h0,        16'd3},     1'b0, 1'b1, '{16'h0000, 16'd2, 1'b1}},
		'{'{WAVE_SAWTOOTH, 32'h40000000, 32'h0,        16'd3},     1'b0, 1'b1, '{16'h8000, 16'd0, 1'b0}},
		'{'{WAVE_SAWTOOTH, 32'h40000000, 32'h0,        16'd3},     1'b0, 1'b1, '{16'hC000, 16'd1, 1'b0}},
		'{'{WAVE_SAWTOOTH, 32'h40000000, 32'h0,        16'd3},     1'b1, 1'b1, '{16'h8000, 16'd0, 1'b0}},
		'{'{WAVE_SINE,     32'hFFFFFFFF, 32'h0,        16'hFFFF},  1'b1, 1'b0, '{16'h0000, 16'd0, 1'b0}},
		'{'{WAVE_SINE,     32'hFFFFFFFF, 32'h0,        16'hFFFF},  1'b0, 1'b0, '{16'h0000, 16'd0, 1'b0}},
		'{'{WAVE_SINE,     32'hFFFFFFFF, 32'h0,        16'hFFFF},  1'b0, 1'b0, '{16'h0000, 16'd0, 1'b0}},
		'{'{WAVE_COSINE,   32'h80000000, 32'h40000000, 16'hFFFF},  1'b0, 1'b0, '{16'h0000, 16'd0, 1'b0}}
	};

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: a new setting is loaded only once the block is idle
		foreach (dir_rows[r]) begin
			if (!have_cfg || dir_rows[r].cfg != live_cfg) begin
				settle();
				apply_cfg(dir_rows[r].cfg);
			end
			pin_q.insert(pin_q.size(), {dir_rows[r].pinned, dir_rows[r].want});
			send_tick(dir_rows[r].restart);
		end

		// Random part: four idling profiles, several settings in each
		for (int ph = 0; ph < 4; ph++) begin
			settle();
			case (ph)
				0: begin send_idle_pct = 0;  stall_pct <= 0;  end
				1: begin send_idle_pct = 70; stall_pct <= 0;  end
				2: begin send_idle_pct = 0;  stall_pct <= 70; end
				default: begin send_idle_pct = 16; stall_pct <= 16; end
			endcase
			for (int seg = 0; seg < 4; seg++) begin
				settle();
				apply_cfg(pick_cfg());
				for (int n = 0; n < SEG_ITEMS; n++)
					send_tick($urandom_range(0, 19) == 0);
			end
		end

		// Long receiver hold-off while the sender keeps offering items
		settle();
		send_idle_pct = 0;
		stall_pct <= 0;
		apply_cfg(pick_cfg());
		fork
			hold_receiver(300);
			for (int n = 0; n < 60; n++)
				send_tick($urandom_range(0, 19) == 0);
		join
		settle();
		repeat (10) @(posedge clk);

		if (mismatches == 0 && sample_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
